// ===== design/assert_macros.svh =====
// Assertion macros shared by the key matrix scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define KM_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define KM_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define KM_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/kmdeq_pkg.sv =====
// Package with constants, codes and interface types of the key matrix scanner.
package kmdeq_pkg;

    localparam int ROWS_DEF        = 6;
    localparam int COLS_DEF        = 14;
    localparam int QUEUE_SLOTS_DEF = 64;

    localparam int ACTION_W = 2;
    localparam int ROW_W    = 3;
    localparam int BITS_W   = 14;
    localparam int TIME_W   = 32;
    localparam int ECOL_W   = 4;
    localparam int COUNT_W  = 4;
    localparam int LEVEL_W  = 6;
    localparam int EVENT_W  = TIME_W + 1 + ECOL_W + ROW_W;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = ACTION_W;
    localparam int M_TDATA_W = 56;
    localparam int M_TUSER_W = 1;

    localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

    localparam logic [ACTION_W-1:0] ACT_SCAN  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_POP   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    typedef struct packed {
        logic sweep_step;
        logic latch;
        logic scan_start;
        logic scan_issue;
        logic row_commit;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic sweep_done;
        logic scan_go;
        logic issue_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

// ===== design/key_matrix_debounce_event_queue.sv =====
// Top level of the key matrix scanner with per-key debounce and event ring.
// A scan word passes dispatch, the column loop that reads one key time per cycle, a drain
// that commits the row and a finish that registers the result; no new word is taken before.
// Pop, clear and unused words pass only dispatch and the finish that registers the result;
// a result waiting on m_tready stalls only the next finish.
// After aresetn the key time memory is cleared, one entry a cycle, all ROWS*COLS entries
// (84 by default), with s_tready low; the configuration port is taken throughout.
module key_matrix_debounce_event_queue #(
    parameter int ROWS        = kmdeq_pkg::ROWS_DEF,
    parameter int COLS        = kmdeq_pkg::COLS_DEF,
    parameter int QUEUE_SLOTS = kmdeq_pkg::QUEUE_SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // row_index, column_bits, now_ms
    input  logic [kmdeq_pkg::S_TDATA_W-1:0]  s_tdata,
    // action
    input  logic [kmdeq_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // event_row, event_col, event_pressed, event_time, queued_count, dropped_count,
    // queue_level
    output logic [kmdeq_pkg::M_TDATA_W-1:0]  m_tdata,
    // event_valid
    output logic [kmdeq_pkg::M_TUSER_W-1:0]  m_tuser,
    input  logic                             cfg_wr_en,
    input  logic [15:0]                      cfg_wr_data
);
    import kmdeq_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    kmdeq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kmdeq_datapath #(
        .ROWS        (ROWS),
        .COLS        (COLS),
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ===== design/kmdeq_ctrl.sv =====
// Controller state machine that sequences sweep, scan, pop and clear words.
`include "assert_macros.svh"

module kmdeq_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  kmdeq_pkg::ctrl_sts_t  sts,
    output kmdeq_pkg::ctrl_cmd_t  cmd
);
    import kmdeq_pkg::*;

    localparam logic [2:0] ST_SWEEP    = 3'd0;
    localparam logic [2:0] ST_IDLE     = 3'd1;
    localparam logic [2:0] ST_DISPATCH = 3'd2;
    localparam logic [2:0] ST_SCAN     = 3'd3;
    localparam logic [2:0] ST_DRAIN    = 3'd4;
    localparam logic [2:0] ST_FIN      = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_SWEEP: begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (sts.scan_go) begin
                    cmd.scan_start = 1'b1;
                    state_next     = ST_SCAN;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (sts.issue_last) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                cmd.row_commit = 1'b1;
                state_next     = ST_FIN;
            end
            ST_FIN: begin
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_SWEEP;
        end else begin
            state_reg <= state_next;
        end
    end

    `KM_ASSERT_NEXT(a_scan_runs, aclk, aresetn, (state_reg == ST_SCAN) && !sts.issue_last, state_reg == ST_SCAN, "scan left before last column")

endmodule

// ===== design/kmdeq_datapath.sv =====
// Datapath with row store, key time memory, event ring and output register.
`include "assert_macros.svh"

module kmdeq_datapath #(
    parameter int ROWS        = kmdeq_pkg::ROWS_DEF,
    parameter int COLS        = kmdeq_pkg::COLS_DEF,
    parameter int QUEUE_SLOTS = kmdeq_pkg::QUEUE_SLOTS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic [kmdeq_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [kmdeq_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [kmdeq_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [kmdeq_pkg::M_TUSER_W-1:0]    m_tuser,
    input  logic                               cfg_wr_en,
    input  logic [15:0]                        cfg_wr_data,
    input  kmdeq_pkg::ctrl_cmd_t               cmd,
    output kmdeq_pkg::ctrl_sts_t               sts
);
    import kmdeq_pkg::*;

    localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW       = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int PW       = $clog2(QUEUE_SLOTS);
    localparam int LT_DEPTH = ROWS * COLS;
    localparam int LT_AW    = (LT_DEPTH > 1) ? $clog2(LT_DEPTH) : 1;
    localparam int CNT_W    = $clog2(COLS + 1);

    logic [15:0]          debounce_reg;
    logic [ACTION_W-1:0]  action_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [COLS-1:0]      bits_reg;
    logic [TIME_W-1:0]    now_reg;

    logic [COLS-1:0]      prev_rows_reg [ROWS];
    logic [COLS-1:0]      prev_row_reg;
    logic [LT_AW-1:0]     base_reg;
    logic [CW-1:0]        col_reg;
    logic [LT_AW-1:0]     sweep_reg;

    logic                 s1_valid_reg;
    logic                 s1_changed_reg;
    logic                 s1_bit_reg;
    logic [CW-1:0]        s1_col_reg;
    logic [LT_AW-1:0]     s1_addr_reg;

    logic [TIME_W-1:0]    lt_mem [LT_DEPTH];
    logic [TIME_W-1:0]    lt_rdata_reg;
    logic [EVENT_W-1:0]   ev_mem [QUEUE_SLOTS];
    logic [EVENT_W-1:0]   ev_rdata_reg;

    logic [PW-1:0]        rd_ptr_reg;
    logic [PW-1:0]        wr_ptr_reg;
    logic [PW-1:0]        rd_ptr_next;
    logic [PW-1:0]        wr_ptr_next;
    logic [CNT_W-1:0]     queued_reg;
    logic [CNT_W-1:0]     dropped_reg;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;
    logic                 m_tuser_reg;
    logic                 m_tuser_next;

    logic [RW+ROW_W-1:0]  row_ext;
    logic [RW-1:0]        row_idx;
    logic [COLS+BITS_W-1:0] bits_ext;
    logic                 row_ok;
    logic [LT_AW-1:0]     issue_addr;
    logic                 lt_we;
    logic [LT_AW-1:0]     lt_waddr;
    logic [TIME_W-1:0]    lt_wdata;
    logic [TIME_W-1:0]    diff;
    logic                 chk_accept;
    logic [PW-1:0]        wr_inc;
    logic [PW-1:0]        rd_inc;
    logic                 full;
    logic                 push;
    logic                 drop;
    logic                 pop_ok;
    logic                 do_clear;
    logic [PW:0]          level;

    assign row_ext  = {{RW{1'b0}}, row_reg};
    assign row_idx  = row_ext[RW-1:0];
    assign bits_ext = {{COLS{1'b0}}, s_tdata[16:3]};
    assign row_ok   = (32'(row_reg) < ROWS);

    assign issue_addr = base_reg + LT_AW'(col_reg);
    assign diff       = now_reg - lt_rdata_reg;
    assign chk_accept = s1_valid_reg && s1_changed_reg && !diff[TIME_W-1]
                        && (diff >= {16'd0, debounce_reg});

    assign lt_we    = cmd.sweep_step || chk_accept;
    assign lt_waddr = cmd.sweep_step ? sweep_reg : s1_addr_reg;
    assign lt_wdata = cmd.sweep_step ? '0 : now_reg;

    assign wr_inc = (wr_ptr_reg == PW'(QUEUE_SLOTS - 1)) ? '0 : wr_ptr_reg + 1'b1;
    assign rd_inc = (rd_ptr_reg == PW'(QUEUE_SLOTS - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign full   = (wr_inc == rd_ptr_reg);
    assign push   = chk_accept && !full;
    assign drop   = chk_accept && full;

    assign pop_ok   = cmd.finish && (action_reg == ACT_POP) && (rd_ptr_reg != wr_ptr_reg);
    assign do_clear = cmd.finish && (action_reg == ACT_CLEAR);

    always_comb begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        if (do_clear) begin
            rd_ptr_next = '0;
            wr_ptr_next = '0;
        end else begin
            if (pop_ok) begin
                rd_ptr_next = rd_inc;
            end
            if (push) begin
                wr_ptr_next = wr_inc;
            end
        end
    end

    always_comb begin
        if (wr_ptr_next >= rd_ptr_next) begin
            level = {1'b0, wr_ptr_next} - {1'b0, rd_ptr_next};
        end else begin
            level = {1'b0, wr_ptr_next} + (PW+1)'(QUEUE_SLOTS) - {1'b0, rd_ptr_next};
        end
    end

    always_comb begin
        m_tdata_next = '0;
        m_tuser_next = 1'b0;
        m_tdata_next[53:48] = LEVEL_W'(level);
        if (pop_ok) begin
            m_tuser_next       = 1'b1;
            m_tdata_next[39:0] = ev_rdata_reg;
        end
        if ((action_reg == ACT_SCAN) && row_ok) begin
            m_tdata_next[43:40] = COUNT_W'(queued_reg);
            m_tdata_next[47:44] = COUNT_W'(dropped_reg);
        end
    end

    assign sts.sweep_done = (sweep_reg == LT_AW'(LT_DEPTH - 1));
    assign sts.scan_go    = (action_reg == ACT_SCAN) && row_ok;
    assign sts.issue_last = (col_reg == CW'(COLS - 1));
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (lt_we) begin
            lt_mem[lt_waddr] <= lt_wdata;
        end
        lt_rdata_reg <= lt_mem[issue_addr];
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ev_mem[wr_ptr_reg] <= {now_reg, s1_bit_reg, ECOL_W'(s1_col_reg), row_reg};
        end
        ev_rdata_reg <= ev_mem[rd_ptr_reg];
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            action_reg <= s_tuser;
            row_reg    <= s_tdata[2:0];
            bits_reg   <= bits_ext[COLS-1:0];
            now_reg    <= s_tdata[48:17];
        end
        if (cmd.scan_start) begin
            prev_row_reg <= prev_rows_reg[row_idx];
            base_reg     <= LT_AW'(32'(row_reg) * COLS);
        end
        if (cmd.scan_issue) begin
            s1_changed_reg <= bits_reg[col_reg] != prev_row_reg[col_reg];
            s1_bit_reg     <= bits_reg[col_reg];
            s1_col_reg     <= col_reg;
            s1_addr_reg    <= issue_addr;
        end
        if (cmd.finish) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg  <= DEBOUNCE_RESET;
            prev_rows_reg <= '{default: '0};
            col_reg       <= '0;
            sweep_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            rd_ptr_reg    <= '0;
            wr_ptr_reg    <= '0;
            queued_reg    <= '0;
            dropped_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                debounce_reg <= cfg_wr_data;
            end
            if (cmd.sweep_step) begin
                sweep_reg <= sweep_reg + 1'b1;
            end
            if (cmd.scan_start) begin
                col_reg     <= '0;
                queued_reg  <= '0;
                dropped_reg <= '0;
            end else if (cmd.scan_issue) begin
                col_reg <= col_reg + 1'b1;
            end
            s1_valid_reg <= cmd.scan_issue;
            if (push) begin
                queued_reg <= queued_reg + 1'b1;
            end
            if (drop) begin
                dropped_reg <= dropped_reg + 1'b1;
            end
            if (cmd.row_commit) begin
                prev_rows_reg[row_idx] <= bits_reg;
            end
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            if (cmd.finish) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    `KM_ASSERT(a_counts_bounded, aclk, aresetn, (32'(queued_reg) + 32'(dropped_reg)) <= COLS, "more events than columns in one row")
    `KM_ASSERT(a_ptrs_in_range, aclk, aresetn, (32'(rd_ptr_reg) < QUEUE_SLOTS) && (32'(wr_ptr_reg) < QUEUE_SLOTS), "ring pointer out of range")
    `KM_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, m_tvalid_reg && !m_tready, !cmd.finish, "result word overwritten while stalled")

endmodule

// ===== tb/key_event_checker.sv =====
// Checker that predicts and compares every result word of the key matrix scanner.
module key_event_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [55:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,
    input  logic [0:0]  m_tuser,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    output int          failures,
    output int          pending
);
    import kmdeq_pkg::*;

    typedef struct {
        logic        valid;
        logic [2:0]  row;
        logic [3:0]  col;
        logic        pressed;
        logic [31:0] stamp;
        logic [3:0]  queued;
        logic [3:0]  dropped;
        logic [5:0]  level;
    } key_report_t;

    typedef struct {
        logic [2:0]  row;
        logic [3:0]  col;
        logic        pressed;
        logic [31:0] stamp;
    } key_entry_t;

    logic [15:0]  debounce;
    logic [13:0]  prev_rows [ROWS_DEF];
    logic [31:0]  key_time [ROWS_DEF*COLS_DEF];
    key_entry_t   ring [QUEUE_SLOTS_DEF];
    int           rd_ptr;
    int           wr_ptr;
    key_report_t  predicted_reports [$];
    key_report_t  want;
    key_report_t  got;

    initial begin
        failures = 0;
        pending  = 0;
    end

    function automatic key_report_t next_report(input logic [1:0] act, input logic [2:0] row,
                                                input logic [13:0] bits, input logic [31:0] now);
        key_report_t r;
        logic [31:0] gap;
        int key;
        int nxt;
        r = '{default: '0};
        case (act)
            ACT_SCAN: begin
                if (row < ROWS_DEF) begin
                    for (int c = 0; c < COLS_DEF; c++) begin
                        if (bits[c] != prev_rows[row][c]) begin
                            key = row * COLS_DEF + c;
                            gap = now - key_time[key];
                            if (!gap[31] && gap >= 32'(debounce)) begin
                                key_time[key] = now;
                                nxt = (wr_ptr + 1) % QUEUE_SLOTS_DEF;
                                if (nxt == rd_ptr) begin
                                    r.dropped++;
                                end else begin
                                    ring[wr_ptr] = '{row, 4'(c), bits[c], now};
                                    wr_ptr = nxt;
                                    r.queued++;
                                end
                            end
                        end
                    end
                    prev_rows[row] = bits;
                end
            end
            ACT_POP: begin
                if (rd_ptr != wr_ptr) begin
                    r.valid   = 1'b1;
                    r.row     = ring[rd_ptr].row;
                    r.col     = ring[rd_ptr].col;
                    r.pressed = ring[rd_ptr].pressed;
                    r.stamp   = ring[rd_ptr].stamp;
                    rd_ptr    = (rd_ptr + 1) % QUEUE_SLOTS_DEF;
                end
            end
            ACT_CLEAR: begin
                rd_ptr = 0;
                wr_ptr = 0;
            end
            default: ;
        endcase
        r.level = 6'((wr_ptr - rd_ptr + QUEUE_SLOTS_DEF) % QUEUE_SLOTS_DEF);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input longint unsigned exp_val,
                                   input longint unsigned act_val);
        if (failures < 60)
            $display("%0t: %s wrong, expected 0x%0h, got 0x%0h", $time, field, exp_val, act_val);
        failures++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            debounce = DEBOUNCE_RESET;
            foreach (prev_rows[i]) prev_rows[i] = '0;
            foreach (key_time[i]) key_time[i] = '0;
            rd_ptr = 0;
            wr_ptr = 0;
            predicted_reports.delete();
        end else begin
            if (cfg_wr_en)
                debounce = cfg_wr_data;
            if (s_tvalid && s_tready)
                predicted_reports.push_back(next_report(s_tuser, s_tdata[2:0], s_tdata[16:3],
                                                        s_tdata[48:17]));
            if (m_tvalid && m_tready) begin
                got.valid   = m_tuser[0];
                got.row     = m_tdata[2:0];
                got.col     = m_tdata[6:3];
                got.pressed = m_tdata[7];
                got.stamp   = m_tdata[39:8];
                got.queued  = m_tdata[43:40];
                got.dropped = m_tdata[47:44];
                got.level   = m_tdata[53:48];
                if (predicted_reports.size() == 0) begin
                    report_mismatch("unexpected result word", 0, m_tdata);
                end else begin
                    want = predicted_reports.pop_front();
                    if (got.valid !== want.valid)
                        report_mismatch("event_valid", want.valid, got.valid);
                    if (got.row !== want.row)
                        report_mismatch("event_row", want.row, got.row);
                    if (got.col !== want.col)
                        report_mismatch("event_col", want.col, got.col);
                    if (got.pressed !== want.pressed)
                        report_mismatch("event_pressed", want.pressed, got.pressed);
                    if (got.stamp !== want.stamp)
                        report_mismatch("event_time", want.stamp, got.stamp);
                    if (got.queued !== want.queued)
                        report_mismatch("queued_count", want.queued, got.queued);
                    if (got.dropped !== want.dropped)
                        report_mismatch("dropped_count", want.dropped, got.dropped);
                    if (got.level !== want.level)
                        report_mismatch("queue_level", want.level, got.level);
                end
            end
        end
        pending <= predicted_reports.size();
    end

endmodule

// ===== tb/tb.sv =====
// Stimulus, clocking and verdict for the key matrix scanner testbench.
module tb;
    import kmdeq_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         HOLD_CYCLES = 400;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    // row_index, column_bits, now_ms
    logic [55:0] s_tdata;
    // action
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // event_row, event_col, event_pressed, event_time, queued_count, dropped_count,
    // queue_level
    logic [55:0] m_tdata;
    // event_valid
    logic [0:0]  m_tuser;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    int          failures;
    int          pending;

    logic        hold_req = 1'b0;
    int          idle_pct;
    int          stall_pct;
    int          debounce_now;
    logic [31:0] clock_ms;
    logic [13:0] row_image [8];
    int          n_words, n_scan, n_pop, n_clear, n_unused;

    key_matrix_debounce_event_queue DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    key_event_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .failures    (failures),
        .pending     (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #1200000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // The long hold-off is counted here so that the sender keeps pushing meanwhile.
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req <= 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic send_word(input logic [1:0] act, input logic [2:0] row,
                             input logic [13:0] bits, input logic [31:0] now);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {7'b0, now, bits, row};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n_words++;
        case (act)
            ACT_SCAN:  n_scan++;
            ACT_POP:   n_pop++;
            ACT_CLEAR: n_clear++;
            default:   n_unused++;
        endcase
    endtask

    task automatic wait_quiet();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic set_debounce(input int value);
        wait_quiet();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= 16'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        debounce_now = value;
    endtask

    // Mostly plausible key activity: a few keys toggle per scan while time moves forward.
    task automatic random_word();
        int pick;
        int step;
        logic [2:0] row;
        logic [13:0] bits;
        pick = $urandom_range(99);
        step = $urandom_range(99);
        if (step < 75)
            clock_ms += $urandom_range(2 * debounce_now + 8);
        else if (step < 85)
            clock_ms = $urandom();
        else if (step < 93)
            clock_ms -= $urandom_range(1, 40);
        if (pick < 58) begin
            if ($urandom_range(19) == 0)
                row = 3'($urandom_range(6, 7));
            else
                row = 3'($urandom_range(ROWS_DEF - 1));
            if ($urandom_range(4) == 0) begin
                bits = 14'($urandom());
            end else begin
                bits = row_image[row];
                repeat ($urandom_range(1, 3)) bits[$urandom_range(COLS_DEF - 1)] ^= 1'b1;
            end
            row_image[row] = bits;
            send_word(ACT_SCAN, row, bits, clock_ms);
        end else if (pick < 90) begin
            send_word(ACT_POP, 3'($urandom()), 14'($urandom()), $urandom());
        end else if (pick < 96) begin
            send_word(ACT_CLEAR, 3'($urandom()), 14'($urandom()), $urandom());
        end else begin
            send_word(ACT_UNUSED, 3'($urandom()), 14'($urandom()), $urandom());
        end
    endtask

    initial begin
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        aresetn     <= 1'b0;
        idle_pct     = 0;
        stall_pct    = 0;
        debounce_now = 20;
        clock_ms     = 32'd1000;
        foreach (row_image[i]) row_image[i] = '0;
        n_words = 0;
        n_scan = 0;
        n_pop = 0;
        n_clear = 0;
        n_unused = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed checks at the reset debounce setting.
        send_word(ACT_POP, 3'd0, 14'd0, 32'd0);
        send_word(ACT_UNUSED, 3'd7, 14'h3FFF, 32'hFFFFFFFF);
        send_word(ACT_SCAN, 3'd0, 14'h3FFF, 32'd10);
        send_word(ACT_SCAN, 3'd0, 14'h0000, 32'd100);
        send_word(ACT_SCAN, 3'd5, 14'h2AAA, 32'd119);
        send_word(ACT_SCAN, 3'd6, 14'h3FFF, 32'd500);
        send_word(ACT_SCAN, 3'd7, 14'h1555, 32'd500);
        send_word(ACT_SCAN, 3'd0, 14'h3FFF, 32'hFFFFFFFB);
        send_word(ACT_SCAN, 3'd0, 14'h0000, 32'h7FFFFFFF);
        send_word(ACT_SCAN, 3'd0, 14'h3FFF, 32'h80000000);
        send_word(ACT_SCAN, 3'd5, 14'h1555, 32'h80000000);
        repeat (3) send_word(ACT_POP, 3'd7, 14'h3FFF, 32'hFFFFFFFF);
        send_word(ACT_CLEAR, 3'd0, 14'd0, 32'd0);
        send_word(ACT_POP, 3'd0, 14'd0, 32'd0);

        // With no debounce every toggle counts, so five full-row scans overflow the ring.
        set_debounce(0);
        for (int i = 0; i < 5; i++)
            send_word(ACT_SCAN, 3'd1, (i % 2 == 0) ? 14'h3FFF : 14'h0000, 32'd7);
        send_word(ACT_POP, 3'd0, 14'd0, 32'd0);
        send_word(ACT_SCAN, 3'd1, 14'h0000, 32'd7);
        repeat (2) send_word(ACT_POP, 3'd0, 14'd0, 32'd0);
        send_word(ACT_CLEAR, 3'd0, 14'd0, 32'd0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: set_debounce(65535);
                1: set_debounce(20);
                2: set_debounce(0);
                default: set_debounce($urandom_range(65535));
            endcase
            idle_pct  = (phase == 1) ? 54 : (phase == 3) ? 30 : 0;
            stall_pct = (phase == 2) ? 54 : (phase == 3) ? 30 : 0;
            repeat (100) random_word();
        end

        set_debounce(3);
        idle_pct  = 0;
        stall_pct = 0;
        hold_req <= 1'b1;
        repeat (40) random_word();
        wait_quiet();
        repeat (10) random_word();

        wait_quiet();
        repeat (40) @(posedge aclk);
        $display("Covered %0d words: %0d scans, %0d pops, %0d clears, %0d with the unused code.",
                 n_words, n_scan, n_pop, n_clear, n_unused);
        $display("Debounce ran at 0, 3, 20, 65535 and a random value, with ring overflow, %s",
                 "timestamp wrap, invalid rows and a long output hold-off.");
        if (failures == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
